[hw/rtl/lgke_pkg.sv]
// Shared types and fixed-point constants of the Lorentz factor and kinetic energy block.
`timescale 1ns / 1ps

package lgke_pkg;

  // One particle as it enters the block.
  typedef struct packed {
    logic [15:0]        particle_index;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] scale;
    logic [31:0]        rest_energy;
    logic [31:0]        weight;
    logic               is_last;
  } lgke_in_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [15:0]        index_out;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [31:0]        gamma;
    logic [62:0]        weighted_ke;
    logic [62:0]        total_energy;
    logic               total_done;
  } lgke_out_t;

  // Request to the reciprocal square root unit.
  typedef struct packed {
    logic        start;
    logic [62:0] x;
  } rsq_req_t;

  // Response from the reciprocal square root unit.
  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } rsq_rsp_t;

  // Fixed-point constants.
  localparam logic [31:0] ONE_Q22   = 32'd4194304;
  localparam logic [63:0] ONE_Q62   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] CLAMP_Q62 = 64'd4611681406741369476;
  localparam logic [62:0] MAX63     = 63'h7FFF_FFFF_FFFF_FFFF;
  // 2^106 >> 64: starting partial remainder of the long division.
  localparam logic [63:0] DIV_INIT  = 64'h0000_0400_0000_0000;
  localparam int          DIV_STEPS  = 64;
  localparam int          SQRT_STEPS = 32;

endpackage

[hw/rtl/lgke_mul.sv]
// Shared 33x33 signed multiplier with a registered product.
`timescale 1ns / 1ps

module lgke_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [65:0] prod_r
);

  // The product is available in the cycle after the operands are presented.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[hw/rtl/lgke_rsqrt.sv]
// Bit-serial reciprocal square root: long division of 2^106 by x, then integer square root.
`timescale 1ns / 1ps

module lgke_rsqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  lgke_pkg::rsq_req_t req,
  output lgke_pkg::rsq_rsp_t rsp
);

  typedef enum logic [2:0] {
    RS_IDLE = 3'b001,
    RS_DIV  = 3'b010,
    RS_SQRT = 3'b100
  } rs_state_t;

  rs_state_t   state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [62:0] x_r, x_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] root_r, root_nxt;
  logic        done_r, done_nxt;
  logic [63:0] opa, opb;
  logic [64:0] diff;
  logic        borrow;

  // Operands of the single shared subtractor.
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state_r)
      RS_DIV: begin
        opa = {rem_r[62:0], 1'b0};
        opb = {1'b0, x_r};
      end
      RS_SQRT: begin
        opa = {rem_r[61:0], quo_r[63:62]};
        opb = {30'd0, root_r, 2'b01};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign diff   = {1'b0, opa} - {1'b0, opb};
  assign borrow = diff[64];

  // Sequencer: one quotient bit or one root bit per cycle.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    root_nxt  = root_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      RS_IDLE: begin
        if (req.start) begin
          x_nxt     = req.x;
          rem_nxt   = lgke_pkg::DIV_INIT;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = RS_DIV;
        end
      end
      RS_DIV: begin
        rem_nxt = borrow ? opa : diff[63:0];
        quo_nxt = {quo_r[62:0], ~borrow};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(lgke_pkg::DIV_STEPS - 1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = RS_SQRT;
        end
      end
      RS_SQRT: begin
        rem_nxt  = borrow ? opa : diff[63:0];
        quo_nxt  = {quo_r[61:0], 2'b00};
        root_nxt = {root_r[30:0], ~borrow};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'(lgke_pkg::SQRT_STEPS - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = RS_IDLE;
        end
      end
      default: begin
        state_nxt = RS_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= RS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

[hw/rtl/lorentz_gamma_kinetic_energy.sv]
// Top level: Lorentz factor and weighted relativistic kinetic energy per particle.
`timescale 1ns / 1ps

// Usage
// Input channel in_valid/in_ready/in_data carries one particle per transfer; the
// result channel out_valid/out_ready/out_data carries one result per particle.
// The block works on one particle at a time. in_ready is high only while the
// sequencer is idle. An accepted particle goes through nine products on one
// shared 33x33 multiplier (an issue state and a take state each), a prep state
// that starts the root unit, the root unit itself (a 64-step long division and
// a 32-step square root on one shared subtractor, then a registered done that
// hands the root over) and the load into the output register. Most of the time
// goes to the one-bit-per-cycle divide and square root. The next particle is
// taken the cycle after the load.
// When the receiver stalls, the finished result waits in the output register
// and the block keeps accepting and computing the next particle; that one then
// waits for the output register to free up before it is loaded.
// A synchronous active-low reset returns the sequencer to idle, empties the
// output register and clears the running energy total. The total also clears
// after a result marked last is loaded.
module lorentz_gamma_kinetic_energy (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lgke_pkg::lgke_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lgke_pkg::lgke_out_t out_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ISSUE = 6'b000010,
    ST_TAKE  = 6'b000100,
    ST_PREP  = 6'b001000,
    ST_RSQRT = 6'b010000,
    ST_TOT   = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    OP_VX  = 4'd0,
    OP_VY  = 4'd1,
    OP_VZ  = 4'd2,
    OP_SQX = 4'd3,
    OP_SQY = 4'd4,
    OP_SQZ = 4'd5,
    OP_ERE = 4'd6,
    OP_ALO = 4'd7,
    OP_AHI = 4'd8
  } op_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  lgke_pkg::lgke_in_t  in_r, in_nxt;
  lgke_pkg::lgke_out_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [62:0]         sum_r, sum_nxt;
  logic [31:0]         vx_r, vx_nxt, vy_r, vy_nxt, vz_r, vz_nxt;
  logic [63:0]         b2_r, b2_nxt;
  logic [31:0]         gamma_r, gamma_nxt;
  logic [63:0]         a_r, a_nxt;
  logic [95:0]         acc_r, acc_nxt;
  logic [62:0]         ke_r, ke_nxt;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod;
  logic [95:0]         ke_sum;
  logic [63:0]         b2_clamped, x_full;
  logic [63:0]         tot_full;
  logic [62:0]         total;
  logic                load;
  lgke_pkg::rsq_req_t  rsq_req;
  lgke_pkg::rsq_rsp_t  rsq_rsp;

  // Round half up by 2^24 and saturate to Q1.31.
  function automatic logic [31:0] round_sat(input logic [65:0] p);
    logic [63:0] t;
    logic [39:0] q;
    t = p[63:0] + 64'd8388608;
    q = t[63:24];
    if (q[39:31] == {9{q[39]}}) begin
      return q[31:0];
    end else if (q[39]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  lgke_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  lgke_rsqrt u_rsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rsq_req),
    .rsp   (rsq_rsp)
  );

  // Multiplier operand selection by operation.
  always_comb begin
    unique case (op_r)
      OP_VX: begin
        mul_a = {in_r.vel_x[31], in_r.vel_x};
        mul_b = {in_r.scale[31], in_r.scale};
      end
      OP_VY: begin
        mul_a = {in_r.vel_y[31], in_r.vel_y};
        mul_b = {in_r.scale[31], in_r.scale};
      end
      OP_VZ: begin
        mul_a = {in_r.vel_z[31], in_r.vel_z};
        mul_b = {in_r.scale[31], in_r.scale};
      end
      OP_SQX: begin
        mul_a = {vx_r[31], vx_r};
        mul_b = {vx_r[31], vx_r};
      end
      OP_SQY: begin
        mul_a = {vy_r[31], vy_r};
        mul_b = {vy_r[31], vy_r};
      end
      OP_SQZ: begin
        mul_a = {vz_r[31], vz_r};
        mul_b = {vz_r[31], vz_r};
      end
      OP_ERE: begin
        mul_a = {1'b0, gamma_r - lgke_pkg::ONE_Q22};
        mul_b = {1'b0, in_r.rest_energy};
      end
      OP_ALO: begin
        mul_a = {1'b0, a_r[31:0]};
        mul_b = {1'b0, in_r.weight};
      end
      OP_AHI: begin
        mul_a = {1'b0, a_r[63:32]};
        mul_b = {1'b0, in_r.weight};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Clamp beta squared and form one minus beta squared for the root unit.
  assign b2_clamped    = (b2_r > lgke_pkg::CLAMP_Q62) ? lgke_pkg::CLAMP_Q62 : b2_r;
  assign x_full        = lgke_pkg::ONE_Q62 - b2_clamped;
  assign rsq_req.start = (state_r == ST_PREP);
  assign rsq_req.x     = x_full[62:0];

  // Weighted energy: low and high partial products summed, then shifted down by 38.
  assign ke_sum = acc_r + {prod[63:0], 32'd0};

  // Saturating running total.
  assign tot_full = {1'b0, sum_r} + {1'b0, ke_r};
  assign total    = tot_full[63] ? lgke_pkg::MAX63 : tot_full[62:0];

  assign load = (state_r == ST_TOT) && (!out_valid_r || out_ready);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    sum_nxt       = sum_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    vz_nxt        = vz_r;
    b2_nxt        = b2_r;
    gamma_nxt     = gamma_r;
    a_nxt         = a_r;
    acc_nxt       = acc_r;
    ke_nxt        = ke_r;

    // A taken result frees the output register.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          op_nxt    = OP_VX;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_TAKE;
      end
      ST_TAKE: begin
        unique case (op_r)
          OP_VX:   vx_nxt  = round_sat(prod);
          OP_VY:   vy_nxt  = round_sat(prod);
          OP_VZ:   vz_nxt  = round_sat(prod);
          OP_SQX:  b2_nxt  = prod[63:0];
          OP_SQY:  b2_nxt  = b2_r + prod[63:0];
          OP_SQZ:  b2_nxt  = b2_r + prod[63:0];
          OP_ERE:  a_nxt   = prod[63:0];
          OP_ALO:  acc_nxt = {32'd0, prod[63:0]};
          OP_AHI:  ke_nxt  = {5'd0, ke_sum[95:38]};
          default: b2_nxt  = b2_r;
        endcase
        op_nxt = op_t'(op_r + 4'd1);
        priority if (op_r == OP_SQZ) begin
          state_nxt = ST_PREP;
        end else if (op_r == OP_AHI) begin
          state_nxt = ST_TOT;
        end else begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_PREP: begin
        state_nxt = ST_RSQRT;
      end
      ST_RSQRT: begin
        if (rsq_rsp.done) begin
          gamma_nxt = rsq_rsp.root;
          op_nxt    = OP_ERE;
          state_nxt = ST_ISSUE;
        end
      end
      ST_TOT: begin
        if (load) begin
          out_nxt.index_out    = in_r.particle_index;
          out_nxt.new_vel_x    = vx_r;
          out_nxt.new_vel_y    = vy_r;
          out_nxt.new_vel_z    = vz_r;
          out_nxt.gamma        = gamma_r;
          out_nxt.weighted_ke  = ke_r;
          out_nxt.total_energy = total;
          out_nxt.total_done   = in_r.is_last;
          out_valid_nxt        = 1'b1;
          sum_nxt              = in_r.is_last ? '0 : total;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers and the running total.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    in_r    <= in_nxt;
    out_r   <= out_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    vz_r    <= vz_nxt;
    b2_r    <= b2_nxt;
    gamma_r <= gamma_nxt;
    a_r     <= a_nxt;
    acc_r   <= acc_nxt;
    ke_r    <= ke_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A last particle leaves the running total cleared.
  ap_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_r.is_last) |=> (sum_r == '0))
    else $error("running total not cleared after last particle");

  // Otherwise the running total carries the reported total forward.
  ap_sum_carry: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !in_r.is_last) |=> (sum_r == out_r.total_energy))
    else $error("running total differs from reported total");

  // The root unit only finishes while the sequencer waits for it.
  ap_rsqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsq_rsp.done |-> (state_r == ST_RSQRT))
    else $error("root unit finished outside its wait state");

  // Gamma is never below one.
  ap_gamma_floor: assert property (@(posedge clk) disable iff (!rst_n)
    rsq_rsp.done |-> (rsq_rsp.root[31:22] != 10'd0))
    else $error("gamma below one");

  // A transfer in starts the sequence with the first velocity product.
  ap_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_ISSUE && op_r == OP_VX))
    else $error("sequence did not start after transfer in");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the Lorentz factor and kinetic energy block.
`timescale 1ns / 1ps

module testbench;

  localparam int                 CYCLE_LIMIT    = 1_000_000;
  localparam int                 RANDOM_PER_PHASE = 275;
  localparam int                 DRAIN_CYCLES   = 300;
  localparam logic signed [31:0] SCALE_ONE      = 32'sh0100_0000;
  localparam logic signed [31:0] VEL_MAX        = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VEL_MIN        = 32'sh8000_0000;
  localparam logic [31:0]        U32_MAX        = 32'hFFFF_FFFF;
  localparam logic [31:0]        WEIGHT_ONE     = 32'h0001_0000;

  // One directed stimulus row; known_valid marks a hand-written expectation.
  typedef struct {
    lgke_pkg::lgke_in_t  item;
    bit                  known_valid;
    lgke_pkg::lgke_out_t known;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  lgke_pkg::lgke_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  lgke_pkg::lgke_out_t out_data;

  // Predictor state and scoreboard.
  logic [62:0]         energy_acc;
  lgke_pkg::lgke_out_t pending_results[$];
  stim_row_t           directed_rows[$];
  lgke_pkg::lgke_out_t want;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  errors;
  int                  particles_sent;
  int                  results_checked;
  int                  sets_closed;
  int                  saturated_totals;
  int                  cycle_count;

  lorentz_gamma_kinetic_energy uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock.
  always #4 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Q1.31 times Q8.24 with round half up, saturated back to Q1.31.
  function automatic logic signed [31:0] scaled_component(logic signed [31:0] v,
                                                           logic signed [31:0] s);
    logic signed [63:0] ve;
    logic signed [63:0] se;
    logic signed [63:0] q;
    ve = 64'(v);
    se = 64'(s);
    q  = (ve * se + 64'sd8388608) >>> 24;
    if (q > 64'sd2147483647) return VEL_MAX;
    if (q < -64'sd2147483648) return VEL_MIN;
    return q[31:0];
  endfunction

  // Square of a Q1.31 component as unsigned Q2.62.
  function automatic logic [63:0] square_q62(logic signed [31:0] v);
    logic signed [63:0] ve;
    ve = 64'(v);
    return ve * ve;
  endfunction

  // Largest g below 2^32 with g*g*x no greater than 2^106, found bit by bit.
  function automatic logic [31:0] lorentz_gamma(logic [63:0] x);
    logic [31:0]  g;
    logic [31:0]  trial;
    logic [127:0] prod;
    int           b;
    g = '0;
    for (b = 31; b >= 0; b--) begin
      trial = g | (32'd1 << b);
      prod  = ({96'd0, trial} * {96'd0, trial}) * {64'd0, x};
      if (prod <= (128'd1 << 106)) g = trial;
    end
    return g;
  endfunction

  // Expected result of one particle; advances the running energy total.
  function automatic lgke_pkg::lgke_out_t predict_particle(lgke_pkg::lgke_in_t p);
    lgke_pkg::lgke_out_t r;
    logic [63:0]         b2;
    logic [63:0]         gamma_excess;
    logic [63:0]         rest;
    logic [127:0]        weighted;
    logic [62:0]         ke;
    logic [63:0]         total;
    r.index_out = p.particle_index;
    r.new_vel_x = scaled_component(p.vel_x, p.scale);
    r.new_vel_y = scaled_component(p.vel_y, p.scale);
    r.new_vel_z = scaled_component(p.vel_z, p.scale);
    b2 = square_q62(r.new_vel_x) + square_q62(r.new_vel_y) + square_q62(r.new_vel_z);
    if (b2 > lgke_pkg::CLAMP_Q62) b2 = lgke_pkg::CLAMP_Q62;
    r.gamma      = lorentz_gamma(lgke_pkg::ONE_Q62 - b2);
    gamma_excess = {32'd0, r.gamma - lgke_pkg::ONE_Q22};
    rest         = {32'd0, p.rest_energy};
    weighted     = {64'd0, gamma_excess * rest} * {96'd0, p.weight};
    ke           = weighted[100:38];
    total        = {1'b0, energy_acc} + {1'b0, ke};
    if (total > {1'b0, lgke_pkg::MAX63}) total = {1'b0, lgke_pkg::MAX63};
    r.weighted_ke  = ke;
    r.total_energy = total[62:0];
    r.total_done   = p.is_last;
    energy_acc     = p.is_last ? '0 : total[62:0];
    return r;
  endfunction

  function automatic lgke_pkg::lgke_in_t particle(logic [15:0] idx, logic signed [31:0] vx,
                                                  logic signed [31:0] vy,
                                                  logic signed [31:0] vz,
                                                  logic signed [31:0] sc, logic [31:0] rest,
                                                  logic [31:0] wt, logic last);
    lgke_pkg::lgke_in_t p;
    p.particle_index = idx;
    p.vel_x          = vx;
    p.vel_y          = vy;
    p.vel_z          = vz;
    p.scale          = sc;
    p.rest_energy    = rest;
    p.weight         = wt;
    p.is_last        = last;
    return p;
  endfunction

  // Result of a particle at rest after scaling, with the running total at zero.
  function automatic lgke_pkg::lgke_out_t at_rest(logic [15:0] idx, logic last);
    lgke_pkg::lgke_out_t r;
    r                = '0;
    r.index_out      = idx;
    r.gamma          = lgke_pkg::ONE_Q22;
    r.total_done     = last;
    return r;
  endfunction

  function automatic void add_row(lgke_pkg::lgke_in_t item, bit known_valid = 1'b0,
                                  lgke_pkg::lgke_out_t known = '0);
    stim_row_t row;
    row.item        = item;
    row.known_valid = known_valid;
    row.known       = known;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Signed value spread evenly around zero, magnitude at most 2^28.
  function automatic logic signed [31:0] small_velocity();
    return $signed($urandom_range(32'h1FFF_FFFF)) - 32'sh1000_0000;
  endfunction

  function automatic logic signed [31:0] extreme_velocity();
    case ($urandom_range(4))
      0:       return '0;
      1:       return VEL_MAX;
      2:       return VEL_MIN;
      3:       return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic logic [31:0] random_magnitude(logic [31:0] unit);
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(unit);
      2:       return $urandom_range(U32_MAX, 32'hF000_0000);
      default: return $urandom_range(1) ? U32_MAX : '0;
    endcase
  endfunction

  // Random particle with a mix of slow, fast, extreme and arbitrary velocities.
  function automatic lgke_pkg::lgke_in_t random_particle(logic last);
    lgke_pkg::lgke_in_t p;
    p.particle_index = 16'($urandom);
    case ($urandom_range(3))
      0: begin
        p.vel_x = $urandom;
        p.vel_y = $urandom;
        p.vel_z = $urandom;
      end
      1: begin
        p.vel_x = small_velocity();
        p.vel_y = small_velocity();
        p.vel_z = small_velocity();
      end
      2: begin
        p.vel_x = $urandom_range(VEL_MAX, 32'h6000_0000);
        if ($urandom_range(1)) p.vel_x = -p.vel_x;
        p.vel_y = small_velocity();
        p.vel_z = small_velocity();
      end
      default: begin
        p.vel_x = extreme_velocity();
        p.vel_y = extreme_velocity();
        p.vel_z = extreme_velocity();
      end
    endcase
    case ($urandom_range(4))
      0: p.scale = SCALE_ONE;
      1: p.scale = SCALE_ONE + $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      2: p.scale = $urandom;
      3: begin
        case ($urandom_range(4))
          0:       p.scale = '0;
          1:       p.scale = VEL_MAX;
          2:       p.scale = VEL_MIN;
          3:       p.scale = -SCALE_ONE;
          default: p.scale = 32'sh0080_0000;
        endcase
      end
      default: p.scale = $urandom_range(32'h0200_0000);
    endcase
    p.rest_energy = random_magnitude(32'd1_000_000);
    p.weight      = random_magnitude(32'h0010_0000);
    p.is_last     = last;
    return p;
  endfunction

  // One transfer on the input channel; the expectation is queued on acceptance.
  task automatic push_particle(lgke_pkg::lgke_in_t p, bit known_valid = 1'b0,
                               lgke_pkg::lgke_out_t known = '0);
    lgke_pkg::lgke_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_particle(p);
    pending_results.insert(pending_results.size(), known_valid ? known : predicted);
    particles_sent++;
    if (p.is_last) sets_closed++;
    if (predicted.total_energy == lgke_pkg::MAX63) saturated_totals++;
    @(negedge clk);
  endtask

  // Hold the input idle until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(string name, logic [63:0] expected_val,
                                      logic [63:0] actual_val);
    if (expected_val !== actual_val) begin
      $display("%0t: particle %0d %s mismatch: expected %h, got %h", $time, want.index_out,
               name, expected_val, actual_val);
      errors++;
    end
  endfunction

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result for particle %0d: got %h", $time,
                 out_data.index_out, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("index_out", 64'(want.index_out), 64'(out_data.index_out));
        check_field("new_vel_x", 64'(want.new_vel_x), 64'(out_data.new_vel_x));
        check_field("new_vel_y", 64'(want.new_vel_y), 64'(out_data.new_vel_y));
        check_field("new_vel_z", 64'(want.new_vel_z), 64'(out_data.new_vel_z));
        check_field("gamma", 64'(want.gamma), 64'(out_data.gamma));
        check_field("weighted_ke", 64'(want.weighted_ke), 64'(out_data.weighted_ke));
        check_field("total_energy", 64'(want.total_energy), 64'(out_data.total_energy));
        check_field("total_done", 64'(want.total_done), 64'(out_data.total_done));
        results_checked++;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int phase;
    int sent_in_phase;
    int set_len;
    int k;
    bit long_set_done;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    energy_acc    = '0;
    errors        = 0;
    cycle_count   = 0;
    send_idle_pct = 26;
    recv_idle_pct = 48;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: field extremes, rounding, saturation, clamp and set ends.
    add_row(particle(16'd0, 0, 0, 0, SCALE_ONE, U32_MAX, U32_MAX, 1'b0), 1'b1,
            at_rest(16'd0, 1'b0));
    add_row(particle(16'hFFFF, VEL_MAX, VEL_MAX, VEL_MAX, 0, U32_MAX, U32_MAX, 1'b1), 1'b1,
            at_rest(16'hFFFF, 1'b1));
    add_row(particle(16'd1, VEL_MIN, VEL_MIN, VEL_MIN, 0, 32'd12345, WEIGHT_ONE, 1'b0), 1'b1,
            at_rest(16'd1, 1'b0));
    add_row(particle(16'd2, VEL_MAX, 0, 0, SCALE_ONE, 32'd1000, WEIGHT_ONE, 1'b0));
    add_row(particle(16'd3, 0, VEL_MIN, 0, SCALE_ONE, 32'd1000, WEIGHT_ONE, 1'b0));
    add_row(particle(16'd4, VEL_MAX, VEL_MAX, VEL_MAX, VEL_MAX, 32'd7, WEIGHT_ONE, 1'b0));
    add_row(particle(16'd5, VEL_MIN, VEL_MIN, VEL_MIN, VEL_MAX, 32'd7, WEIGHT_ONE, 1'b0));
    add_row(particle(16'd6, VEL_MAX, VEL_MIN, 32'sh4000_0000, VEL_MIN, 32'd9, 32'd3, 1'b0));
    add_row(particle(16'd7, 1, -1, 0, 32'sh0080_0000, 32'd100, WEIGHT_ONE, 1'b0));
    add_row(particle(16'd8, -1, 1, -1, 32'sh0080_0001, 32'd100, WEIGHT_ONE, 1'b0));
    add_row(particle(16'd9, 32'sh4000_0000, 0, 0, SCALE_ONE, 32'd1000, WEIGHT_ONE, 1'b0));
    add_row(particle(16'd10, 0, 32'sh6ED9_EBA1, 0, SCALE_ONE, U32_MAX, U32_MAX, 1'b1));
    add_row(particle(16'd11, VEL_MAX, VEL_MAX, VEL_MAX, SCALE_ONE, 0, U32_MAX, 1'b0));
    add_row(particle(16'd12, VEL_MAX, VEL_MAX, VEL_MAX, SCALE_ONE, U32_MAX, 0, 1'b0));
    add_row(particle(16'd13, VEL_MAX, VEL_MAX, VEL_MAX, SCALE_ONE, U32_MAX, U32_MAX, 1'b0));
    add_row(particle(16'd14, 0, 0, VEL_MIN, -SCALE_ONE, U32_MAX, U32_MAX, 1'b1));
    add_row(particle(16'd15, 32'sh1234_5678, -32'sh2345_6789, 32'sh0ABC_DEF0,
                     32'sh0080_0000, 32'hDEAD_BEEF, 32'h0003_8000, 1'b0));
    add_row(particle(16'd16, -32'sh0000_1000, 32'sh7000_0000, -32'sh7000_0000,
                     32'sh00C0_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    add_row(particle(16'hFFFF, 0, 0, 0, SCALE_ONE, U32_MAX, U32_MAX, 1'b1), 1'b1,
            at_rest(16'hFFFF, 1'b1));
    foreach (directed_rows[i]) begin
      push_particle(directed_rows[i].item, directed_rows[i].known_valid,
                    directed_rows[i].known);
    end
    drain_results();

    // Random sets in three back-pressure phases.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent_in_phase = 0;
      long_set_done = 1'b0;
      while (sent_in_phase < RANDOM_PER_PHASE) begin
        // One long set of near-light-speed heavy particles drives the total into saturation.
        if (!long_set_done && sent_in_phase > 60) begin
          for (k = 0; k < 36; k++) begin
            push_particle(particle(16'($urandom), $urandom_range(VEL_MAX, 32'h7F00_0000),
                                   small_velocity(), VEL_MIN, SCALE_ONE,
                                   $urandom_range(U32_MAX, 32'hF000_0000),
                                   $urandom_range(U32_MAX, 32'hF000_0000), k == 35));
          end
          sent_in_phase += 36;
          long_set_done = 1'b1;
        end else begin
          set_len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
          for (k = 0; k < set_len; k++) begin
            push_particle(random_particle(k == set_len - 1));
          end
          sent_in_phase += set_len;
        end
      end
      drain_results();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d particles in %0d sets and checked %0d results;", particles_sent,
             sets_closed, results_checked);
    $display("%0d running totals hit saturation, %0d mismatches.", saturated_totals, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
